/* hdl/vfsdf_pkg.sv */
// ----------------------------------------------------------------------------
// vfsdf_pkg
// Shared types, constants and slow-data helpers for the voice frame framer.
// ----------------------------------------------------------------------------
package vfsdf_pkg;

  localparam int unsigned FramesPerSuperframe = 21;
  localparam int unsigned PosW = 5;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned MsgChars = 20;

  localparam logic [PosW:0] LastPos = (PosW + 1)'(FramesPerSuperframe - 1);
  localparam logic [PosW:0] FrameCount = (PosW + 1)'(FramesPerSuperframe);

  localparam logic [7:0] SyncByte0 = 8'h55;
  localparam logic [7:0] SyncByte1 = 8'h2d;
  localparam logic [7:0] SyncByte2 = 8'h16;
  localparam logic [7:0] EndByte = 8'h55;
  localparam logic [7:0] Scramble0 = 8'h70;
  localparam logic [7:0] Scramble1 = 8'h4f;
  localparam logic [7:0] Scramble2 = 8'h93;
  localparam logic [7:0] BlockMarkBase = 8'h40;
  localparam logic [7:0] FillByte = 8'h66;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_VOICE  = 2'd1,
    KIND_END    = 2'd2
  } frame_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MSG_LOW  = 2'd0,
    REG_MSG_MID  = 2'd1,
    REG_MSG_HIGH = 2'd2
  } cfg_reg_e;

  typedef logic [8*MsgChars-1:0] msg_t;

  typedef struct packed {
    logic [7:0] b2;
    logic [7:0] b1;
    logic [7:0] b0;
  } slow_t;

  function automatic logic [7:0] msg_char(msg_t msg, int unsigned idx);
    return msg[8*idx +: 8];
  endfunction

  function automatic logic [7:0] block_mark(int unsigned blk);
    return (BlockMarkBase + 8'(blk)) ^ Scramble0;
  endfunction

  function automatic slow_t slow_bytes(logic [PosW-1:0] pos, msg_t msg);
    slow_t s;
    unique case (pos)
      5'd0: s = '{b0: SyncByte0, b1: SyncByte1, b2: SyncByte2};
      5'd1: s = '{b0: block_mark(0), b1: msg_char(msg, 0) ^ Scramble1,
                  b2: msg_char(msg, 1) ^ Scramble2};
      5'd2: s = '{b0: msg_char(msg, 2) ^ Scramble0, b1: msg_char(msg, 3) ^ Scramble1,
                  b2: msg_char(msg, 4) ^ Scramble2};
      5'd3: s = '{b0: block_mark(1), b1: msg_char(msg, 5) ^ Scramble1,
                  b2: msg_char(msg, 6) ^ Scramble2};
      5'd4: s = '{b0: msg_char(msg, 7) ^ Scramble0, b1: msg_char(msg, 8) ^ Scramble1,
                  b2: msg_char(msg, 9) ^ Scramble2};
      5'd5: s = '{b0: block_mark(2), b1: msg_char(msg, 10) ^ Scramble1,
                  b2: msg_char(msg, 11) ^ Scramble2};
      5'd6: s = '{b0: msg_char(msg, 12) ^ Scramble0, b1: msg_char(msg, 13) ^ Scramble1,
                  b2: msg_char(msg, 14) ^ Scramble2};
      5'd7: s = '{b0: block_mark(3), b1: msg_char(msg, 15) ^ Scramble1,
                  b2: msg_char(msg, 16) ^ Scramble2};
      5'd8: s = '{b0: msg_char(msg, 17) ^ Scramble0, b1: msg_char(msg, 18) ^ Scramble1,
                  b2: msg_char(msg, 19) ^ Scramble2};
      default: s = '{b0: FillByte ^ Scramble0, b1: FillByte ^ Scramble1,
                     b2: FillByte ^ Scramble2};
    endcase
    return s;
  endfunction

endpackage

/* hdl/vfsdf_in_if.sv */
// ----------------------------------------------------------------------------
// vfsdf_in_if
// Voice slot channel: valid/ready handshake with the slot payload.
// ----------------------------------------------------------------------------
interface vfsdf_in_if;
  logic        valid;
  logic        ready;
  logic        tx_active;
  logic [63:0] voice_bytes_head;
  logic [7:0]  voice_byte_tail;
  logic [15:0] candidate_stream_id;

  modport source (output valid, tx_active, voice_bytes_head, voice_byte_tail,
                  candidate_stream_id, input ready);
  modport sink (input valid, tx_active, voice_bytes_head, voice_byte_tail,
                candidate_stream_id, output ready);
endinterface

/* hdl/vfsdf_out_if.sv */
// ----------------------------------------------------------------------------
// vfsdf_out_if
// Frame channel: valid/ready handshake with one framed result.
// ----------------------------------------------------------------------------
interface vfsdf_out_if;
  import vfsdf_pkg::*;
  logic            valid;
  logic            ready;
  frame_kind_e     frame_kind;
  logic [PosW-1:0] frame_position;
  logic [15:0]     stream_id;
  logic [63:0]     out_voice_head;
  logic [7:0]      out_voice_tail;
  logic [7:0]      slow_byte_0;
  logic [7:0]      slow_byte_1;
  logic [7:0]      slow_byte_2;

  modport source (output valid, frame_kind, frame_position, stream_id, out_voice_head,
                  out_voice_tail, slow_byte_0, slow_byte_1, slow_byte_2, input ready);
  modport sink (input valid, frame_kind, frame_position, stream_id, out_voice_head,
                out_voice_tail, slow_byte_0, slow_byte_1, slow_byte_2, output ready);
endinterface

/* hdl/voice_frame_slow_data_framer.sv */
// ----------------------------------------------------------------------------
// voice_frame_slow_data_framer
// Frames voice slots with superframe position, stream id and slow data.
// ----------------------------------------------------------------------------
//   channel   dir   handshake        beat
//   in_i      in    valid/ready      one voice slot or stop
//   out_o     out   valid/ready      one header, voice or end frame
//   cfg       in    cfg_we_i         one message register write
//
// one beat in, one beat out; an accept is followed in the next cycle by out_o.valid
// a new slot is taken every cycle while out_o is drained or empty
// the result register is the only stage; in_i.ready drops only while it is full
// and out_o.ready is low
// reset sets the header flag and clears position, stream id and message registers
// ----------------------------------------------------------------------------
module voice_frame_slow_data_framer import vfsdf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  vfsdf_in_if.sink            in_i,
  vfsdf_out_if.source         out_o
);

  logic [63:0]     msg_low_q, msg_mid_q;
  logic [31:0]     msg_high_q;
  logic [PosW-1:0] pos_q, pos_d;
  logic            hdr_q, hdr_d;
  logic [15:0]     id_q, id_d;
  logic            out_valid_q;
  logic            accept;

  frame_kind_e     kind_d, kind_q;
  logic [PosW-1:0] opos_q;
  logic [15:0]     oid_q;
  logic [63:0]     ohead_d, ohead_q;
  logic [7:0]      otail_d, otail_q;
  slow_t           slow_d, slow_q, slow_sel;
  logic [PosW-1:0] pos_eff;
  logic [PosW:0]   pos_inc;
  logic [15:0]     id_eff;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_low_q  <= '0;
      msg_mid_q  <= '0;
      msg_high_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MSG_LOW:  msg_low_q  <= cfg_data_i;
        REG_MSG_MID:  msg_mid_q  <= cfg_data_i;
        REG_MSG_HIGH: msg_high_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = !out_valid_q || out_o.ready;

  assign pos_eff  = ({1'b0, pos_q} >= FrameCount) ? LastPos[PosW-1:0] : pos_q;
  assign pos_inc  = {1'b0, pos_eff} + (PosW + 1)'(1);
  assign id_eff   = (id_q == '0) ? in_i.candidate_stream_id : id_q;
  assign slow_sel = slow_bytes(pos_eff, {msg_high_q, msg_mid_q, msg_low_q});

  always_comb begin
    pos_d   = pos_q;
    hdr_d   = hdr_q;
    id_d    = id_q;
    kind_d  = KIND_VOICE;
    ohead_d = '0;
    otail_d = '0;
    slow_d  = '0;
    priority if (!in_i.tx_active) begin
      kind_d = KIND_END;
      slow_d = '{b0: EndByte, b1: EndByte, b2: EndByte};
      pos_d  = '0;
      id_d   = '0;
      hdr_d  = 1'b1;
    end else if (hdr_q) begin
      kind_d = KIND_HEADER;
      id_d   = id_eff;
      hdr_d  = 1'b0;
    end else begin
      id_d    = id_eff;
      ohead_d = in_i.voice_bytes_head;
      otail_d = in_i.voice_byte_tail;
      slow_d  = slow_sel;
      if (pos_inc >= FrameCount) begin
        pos_d = '0;
        hdr_d = 1'b1;
      end else begin
        pos_d = pos_inc[PosW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      hdr_q       <= 1'b1;
      id_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        pos_q <= pos_d;
        hdr_q <= hdr_d;
        id_q  <= id_d;
      end
      if (in_i.ready) begin
        out_valid_q <= in_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= kind_d;
      opos_q  <= pos_eff;
      oid_q   <= in_i.tx_active ? id_eff : id_q;
      ohead_q <= ohead_d;
      otail_q <= otail_d;
      slow_q  <= slow_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.frame_kind     = kind_q;
  assign out_o.frame_position = opos_q;
  assign out_o.stream_id      = oid_q;
  assign out_o.out_voice_head = ohead_q;
  assign out_o.out_voice_tail = otail_q;
  assign out_o.slow_byte_0    = slow_q.b0;
  assign out_o.slow_byte_1    = slow_q.b1;
  assign out_o.slow_byte_2    = slow_q.b2;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, pos_q} < FrameCount)
    else $error("position counter out of range");

  a_stop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !in_i.tx_active |=> pos_q == '0 && hdr_q && id_q == '0)
    else $error("stop did not clear state");

  a_header_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.tx_active && hdr_q |=> !hdr_q && pos_q == $past(pos_q))
    else $error("header slot did not clear flag or moved position");

  a_header_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q == KIND_HEADER |-> slow_q == '0 && ohead_q == '0)
    else $error("header frame carries payload");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted slot produced no frame");

endmodule
